### src/dbc_pkg.sv
package dbc_pkg;

    // Field widths of the request byte stream and of one result.
    localparam int DATA_W    = 8;
    localparam int ELEM_W    = 4;
    localparam int VALUE_W   = 64;
    localparam int LIMIT_W   = 17;
    localparam int HDR_LEN_W = 16;
    localparam int POS_W     = 9;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd1024;

    // Index of the transport stream ID element, the only one with a remaining check.
    localparam logic [ELEM_W-1:0] ELEM_HEADER = 4'd0;
    localparam logic [ELEM_W-1:0] ELEM_TSID   = 4'd1;
    localparam logic [ELEM_W-1:0] ELEM_FINAL  = 4'd15;

    // Byte positions that close the fixed-size elements.
    localparam logic [POS_W-1:0] HEADER_LAST_POS  = 9'd3;
    localparam logic [POS_W-1:0] PAYLOAD_LAST_POS = 9'd5;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_TLV     = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_GROUP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DONE    = 2'd1,
        ST_TYPE_ERR = 2'd2,
        ST_LEN_ERR = 2'd3
    } status_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  element;
        logic [VALUE_W-1:0] value;
        logic [DATA_W-1:0]  value_length;
        status_t            status;
        logic               last;
    } result_t;

    // Expected type code of each element in the fixed layout.
    function automatic logic [DATA_W-1:0] expected_type(input logic [ELEM_W-1:0] idx);
        logic [DATA_W-1:0] t;
        case (idx)
            4'd0:    t = 8'h81;
            4'd1:    t = 8'h01;
            4'd2:    t = 8'h02;
            4'd3:    t = 8'h03;
            4'd4:    t = 8'd50;
            4'd5:    t = 8'd1;
            4'd6:    t = 8'd2;
            4'd7:    t = 8'd4;
            4'd8:    t = 8'd2;
            4'd9:    t = 8'd3;
            4'd10:   t = 8'd49;
            4'd11:   t = 8'd1;
            4'd12:   t = 8'd5;
            4'd13:   t = 8'd1;
            4'd14:   t = 8'd4;
            4'd15:   t = 8'd5;
            default: t = 8'd0;
        endcase
        return t;
    endfunction

    // Shape of each element in the fixed layout.
    function automatic kind_t element_kind(input logic [ELEM_W-1:0] idx);
        kind_t k;
        case (idx)
            4'd0:    k = KIND_HEADER;
            4'd3:    k = KIND_PAYLOAD;
            4'd4:    k = KIND_GROUP;
            4'd7:    k = KIND_GROUP;
            4'd10:   k = KIND_GROUP;
            4'd12:   k = KIND_GROUP;
            default: k = KIND_TLV;
        endcase
        return k;
    endfunction

endpackage

### src/dbc_request_tlv_checker.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------
// data     | in        | data_valid / data_stall   | data_byte, start_req
// result   | out       | result_valid / result_stall | element, value, value_length,
//          |           |                           | status, last
// config   | in        | cfg_write                 | cfg_data (length limit)
//
// One byte is taken per cycle while data_stall is low; the parser state updates at the
// accepting edge and a result, when the byte closes an element, lands at that edge in the
// output register, or in the skid register while the output is held by result_stall.
// A two-entry output stage (output register plus skid register) keeps bytes flowing
// while one result waits; data_stall rises only when both entries are full.
// Reset (rst_n low) leaves the parser idle, both output entries empty and the limit at 1024.
module dbc_request_tlv_checker
    import dbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 data_valid,
    output logic                 data_stall,
    input  logic [DATA_W-1:0]    data_byte,
    input  logic                 start_req,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [ELEM_W-1:0]    element,
    output logic [VALUE_W-1:0]   value,
    output logic [DATA_W-1:0]    value_length,
    output logic [1:0]           status,
    output logic                 last
);

    // Parser state.
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 active_reg,  active_next;
    logic [ELEM_W-1:0]    elem_reg,    elem_next;
    logic [POS_W-1:0]     pos_reg,     pos_next;
    logic [DATA_W-1:0]    elen_reg,    elen_next;
    logic [VALUE_W-1:0]   acc_reg,     acc_next;
    logic [HDR_LEN_W-1:0] rem_reg,     rem_next;
    logic [DATA_W-1:0]    type_reg,    type_next;

    // Output stage.
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg,  out_next;
    result_t skid_reg, skid_next;

    // Per-byte working values.
    logic                 accept;
    logic                 work;
    logic                 done;
    kind_t                kind;
    logic [ELEM_W-1:0]    cur_elem;
    logic [POS_W-1:0]     cur_pos;
    logic [DATA_W-1:0]    cur_elen;
    logic [VALUE_W-1:0]   cur_acc;
    logic [HDR_LEN_W-1:0] cur_rem;
    logic [DATA_W-1:0]    cur_type;
    logic [HDR_LEN_W-1:0] rem_dec;
    logic [HDR_LEN_W-1:0] hdr_len;
    status_t              res_status;
    result_t              res;
    logic                 res_fire;
    logic                 out_free;

    assign accept = data_valid && !data_stall;
    assign work   = accept && (start_req || active_reg);

    // A start byte sees the parser as freshly cleared.
    assign cur_elem = start_req ? ELEM_HEADER : elem_reg;
    assign cur_pos  = start_req ? '0 : pos_reg;
    assign cur_elen = start_req ? '0 : elen_reg;
    assign cur_acc  = start_req ? '0 : acc_reg;
    assign cur_rem  = start_req ? '0 : rem_reg;
    assign cur_type = start_req ? '0 : type_reg;
    assign kind     = element_kind(cur_elem);

    // Declared-length countdown, saturating at zero, skipped in the header.
    assign rem_dec = (kind != KIND_HEADER && cur_rem != '0) ? cur_rem - 1'b1 : cur_rem;

    // Byte decode: type latch, length byte, value accumulation and element end.
    always_comb
    begin
        type_next = cur_type;
        elen_next = cur_elen;
        acc_next  = cur_acc;
        done      = 1'b0;
        if (cur_pos == '0)
        begin
            type_next = data_byte;
        end
        else if (kind == KIND_HEADER)
        begin
            acc_next = {cur_acc[VALUE_W-DATA_W-1:0], data_byte};
            done     = (cur_pos >= HEADER_LAST_POS);
        end
        else if (cur_pos == POS_W'(1))
        begin
            elen_next = data_byte;
            done      = (kind == KIND_GROUP) || (kind == KIND_TLV && data_byte == '0);
        end
        else
        begin
            acc_next = {cur_acc[VALUE_W-DATA_W-1:0], data_byte};
            if (kind == KIND_PAYLOAD)
                done = (cur_pos >= PAYLOAD_LAST_POS);
            else
                done = (cur_pos >= POS_W'(cur_elen) + POS_W'(1));
        end
    end

    assign hdr_len = acc_next[HDR_LEN_W-1:0];

    // Element checks at the closing byte.
    always_comb
    begin
        res_status = ST_OK;
        if (kind == KIND_HEADER)
        begin
            if (LIMIT_W'(hdr_len) >= limit_reg)
                res_status = ST_LEN_ERR;
            else if (type_next != expected_type(ELEM_HEADER))
                res_status = ST_TYPE_ERR;
        end
        else if (type_next != expected_type(cur_elem))
            res_status = ST_TYPE_ERR;
        else if (cur_elem == ELEM_TSID && rem_dec == '0)
            res_status = ST_LEN_ERR;
        else if (cur_elem == ELEM_FINAL)
            res_status = ST_DONE;
    end

    assign res_fire = work && done;

    always_comb
    begin
        res.element      = cur_elem;
        res.value        = acc_next;
        res.value_length = (kind == KIND_HEADER) ? '0 : elen_next;
        res.status       = res_status;
        res.last         = (res_status != ST_OK);
    end

    // Next parser state.
    always_comb
    begin
        active_next = active_reg;
        elem_next   = elem_reg;
        pos_next    = pos_reg;
        if (work)
        begin
            if (done)
            begin
                active_next = (res_status == ST_OK);
                elem_next   = cur_elem + 1'b1;
                pos_next    = '0;
            end
            else
            begin
                active_next = 1'b1;
                elem_next   = cur_elem;
                pos_next    = cur_pos + 1'b1;
            end
        end
    end

    always_comb
    begin
        rem_next = rem_dec;
        if (done && kind == KIND_HEADER && res_status == ST_OK)
            rem_next = hdr_len;
    end

    // Output register with a skid entry behind it.
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (res_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (res_fire)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            active_reg     <= 1'b0;
            elem_reg       <= '0;
            pos_reg        <= '0;
            elen_reg       <= '0;
            acc_reg        <= '0;
            rem_reg        <= '0;
            type_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                limit_reg <= cfg_data;
            active_reg     <= active_next;
            elem_reg       <= elem_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (work)
            begin
                elen_reg <= elen_next;
                acc_reg  <= done ? '0 : acc_next;
                rem_reg  <= rem_next;
                type_reg <= type_next;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign data_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign element      = out_reg.element;
    assign value        = out_reg.value;
    assign value_length = out_reg.value_length;
    assign status       = out_reg.status;
    assign last         = out_reg.last;

    // The skid entry is only ever filled behind an occupied output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // The skid entry fills only when the output was held by a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall))
        else $error("skid entry filled without a stalled output");

    // A terminating result leaves the parser idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res_status != ST_OK) |=> !active_reg)
        else $error("parser still active after a terminating result");

    // A header result never reports a length byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.element == ELEM_HEADER) |-> out_reg.value_length == '0)
        else $error("header result carries a nonzero value length");

endmodule
